// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 22;
    localparam int END_W  = 23;
    localparam int LEN_W  = 23;
    localparam int ASH_W  = 5;
    localparam int ST_W   = 3;

    localparam logic [OP_W-1:0] OP_MARK_FREE     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESERVE       = 3'd1;
    localparam logic [OP_W-1:0] OP_ALLOC_FIXED   = 3'd2;
    localparam logic [OP_W-1:0] OP_ALLOC_ALIGNED = 3'd3;
    localparam logic [OP_W-1:0] OP_FREE          = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_UNALIGNED = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [ST_W-1:0] ST_BUSY      = 3'd3;
    localparam logic [ST_W-1:0] ST_BADALIGN  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] address;
        logic [END_W-1:0]  end_address;
        logic [LEN_W-1:0]  length;
        logic [ASH_W-1:0]  align_shift;
    } bpa_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [ST_W-1:0]   status;
    } bpa_res_t;

endpackage

// ===== rtl/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== rtl/page_bitmap_allocator.sv =====
// A rejected request or undefined opcode goes straight to the result. Mark free, reserve and
// free write their pages; a fixed allocation reads its pages and then writes them, stopping
// at the first page in use, and an aligned one reads each candidate run until one is free and
// then writes it, with a candidate that overruns the store ending the search.
// cmd_ready rises in the same cycle as result valid; a held result stalls the final step.
// Reset: a clearing pass marks every page free, with cmd_ready low.
module page_bitmap_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES       = 1024,
    parameter int PAGE_SHIFT_BITS = 12
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  bpa_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output bpa_res_t res
);

    localparam int AW    = $clog2(NUM_PAGES);
    localparam int NP_W  = $clog2(NUM_PAGES + 1);
    localparam int PG_W  = 24 - PAGE_SHIFT_BITS;
    localparam int CNT_W = ((PG_W > NP_W) ? PG_W : NP_W) + 1;
    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_PAGES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CAND,
        S_CHECK,
        S_FILL,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  cand_reg, cand_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  stop_reg, stop_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ASH_W-1:0]  ash_reg, ash_next;
    logic              unal_reg, unal_next;
    logic              fill_val_reg, fill_val_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic              res_valid_reg, res_valid_next;
    bpa_res_t          res_data_reg, res_data_next;

    logic [CNT_W-1:0]  sum_first;
    logic [CNT_W-1:0]  sum_cand;
    logic [CNT_W-1:0]  stop_clip;
    logic [CNT_W-1:0]  sum_clip;
    logic [ASH_W-1:0]  k;
    logic [CNT_W+PAGE_SHIFT_BITS-1:0] lo_bytes;

    logic              ram_we;
    logic              ram_wdata;
    logic [0:0]        ram_rdata;

    assign sum_first = first_reg + n_reg;
    assign sum_cand  = cand_reg + n_reg;
    assign stop_clip = (stop_reg > NUM_C) ? NUM_C : stop_reg;
    assign sum_clip  = (sum_first > NUM_C) ? NUM_C : sum_first;
    assign k         = ash_reg - ASH_W'(PAGE_SHIFT_BITS);
    assign lo_bytes  = {lo_reg, {PAGE_SHIFT_BITS{1'b0}}};

    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_FILL) && (ptr_reg < hi_reg));
    assign ram_wdata = (state_reg == S_CLEAR) ? 1'b0 : fill_val_reg;

    bpa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_PAGES)
    ) u_bpa_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cand_next      = cand_reg;
        step_next      = step_reg;
        first_next     = first_reg;
        n_next         = n_reg;
        stop_next      = stop_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        ash_next       = ash_reg;
        unal_next      = unal_reg;
        fill_val_next  = fill_val_reg;
        rd_pend_next   = rd_pend_reg;
        res_addr_next  = res_addr_reg;
        st_next        = st_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (ptr_reg == NUM_C - CNT_W'(1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next       = cmd.opcode;
                    addr_next     = cmd.address;
                    ash_next      = cmd.align_shift;
                    unal_next     = |cmd.address[PAGE_SHIFT_BITS-1:0];
                    first_next    = CNT_W'(cmd.address >> PAGE_SHIFT_BITS);
                    stop_next     = CNT_W'(cmd.end_address >> PAGE_SHIFT_BITS);
                    n_next        = CNT_W'(cmd.length >> PAGE_SHIFT_BITS)
                                  + CNT_W'(|cmd.length[PAGE_SHIFT_BITS-1:0]);
                    res_addr_next = '0;
                    st_next       = ST_OK;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (op_reg)
                    OP_MARK_FREE, OP_RESERVE:
                    begin
                        if (unal_reg)
                        begin
                            st_next    = ST_UNALIGNED;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ptr_next      = first_reg;
                            hi_next       = stop_clip;
                            fill_val_next = op_reg[0];
                            state_next    = S_FILL;
                        end
                    end

                    OP_FREE:
                    begin
                        if (unal_reg)
                        begin
                            st_next    = ST_UNALIGNED;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ptr_next      = first_reg;
                            hi_next       = sum_clip;
                            fill_val_next = 1'b0;
                            state_next    = S_FILL;
                        end
                    end

                    OP_ALLOC_FIXED:
                    begin
                        if (unal_reg)
                        begin
                            st_next    = ST_UNALIGNED;
                            state_next = S_FINISH;
                        end
                        else if (sum_first > NUM_C)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            lo_next      = first_reg;
                            ptr_next     = first_reg;
                            hi_next      = sum_first;
                            rd_pend_next = 1'b0;
                            state_next   = S_CHECK;
                        end
                    end

                    OP_ALLOC_ALIGNED:
                    begin
                        if (ash_reg < ASH_W'(PAGE_SHIFT_BITS))
                        begin
                            st_next    = ST_BADALIGN;
                            state_next = S_FINISH;
                        end
                        else if (k >= ASH_W'(NP_W))
                        begin
                            // alignment beyond the store: no candidate at all
                            st_next    = ST_BUSY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            step_next  = CNT_W'(1) << k;
                            cand_next  = CNT_W'(1) << k;
                            state_next = S_CAND;
                        end
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_CAND:
            begin
                // later candidates only sit higher, so an overrun ends the search
                if ((cand_reg >= NUM_C) || (sum_cand > NUM_C))
                begin
                    st_next    = ST_BUSY;
                    state_next = S_FINISH;
                end
                else
                begin
                    lo_next      = cand_reg;
                    ptr_next     = cand_reg;
                    hi_next      = sum_cand;
                    rd_pend_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (rd_pend_reg && ram_rdata[0])
                begin
                    rd_pend_next = 1'b0;
                    if (op_reg == OP_ALLOC_FIXED)
                    begin
                        st_next    = ST_BUSY;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cand_next  = cand_reg + step_reg;
                        state_next = S_CAND;
                    end
                end
                else if (ptr_reg < hi_reg)
                begin
                    ptr_next     = ptr_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next  = 1'b0;
                    ptr_next      = lo_reg;
                    fill_val_next = 1'b1;
                    res_addr_next = (op_reg == OP_ALLOC_FIXED) ? addr_reg
                                                               : lo_bytes[ADDR_W-1:0];
                    state_next    = S_FILL;
                end
            end

            S_FILL:
            begin
                if (ptr_reg < hi_reg)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_data_next.result_address = res_addr_reg;
                    res_data_next.status         = st_reg;
                    res_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            cand_reg      <= '0;
            step_reg      <= '0;
            first_reg     <= '0;
            n_reg         <= '0;
            stop_reg      <= '0;
            op_reg        <= '0;
            addr_reg      <= '0;
            ash_reg       <= '0;
            unal_reg      <= 1'b0;
            fill_val_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            res_addr_reg  <= '0;
            st_reg        <= ST_OK;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            cand_reg      <= cand_next;
            step_reg      <= step_next;
            first_reg     <= first_next;
            n_reg         <= n_next;
            stop_reg      <= stop_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            ash_reg       <= ash_next;
            unal_reg      <= unal_next;
            fill_val_reg  <= fill_val_next;
            rd_pend_reg   <= rd_pend_next;
            res_addr_reg  <= res_addr_next;
            st_reg        <= st_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

endmodule

// ===== rtl/bpa_checker.sv =====
module bpa_checker
    import bpa_pkg::*;
#(
    parameter int PAGE_SHIFT_BITS = 12
) (
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_ready,
    input logic     res_valid,
    input logic     res_ready,
    input bpa_res_t res
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

    // one request in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.status <= ST_BADALIGN)
    else $error("undefined status");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status != ST_OK) |-> res.result_address == '0)
    else $error("address given with failure status");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.result_address[PAGE_SHIFT_BITS-1:0] == '0)
    else $error("result address not on a page boundary");

endmodule

bind page_bitmap_allocator bpa_checker #(
    .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
) u_bpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

// ===== verif/page_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps

module page_bitmap_allocator_tb
    import bpa_pkg::*;
;

    localparam int NPAGES   = 1024;
    localparam int PSHIFT   = 12;
    localparam int PAGE_B   = 1 << PSHIFT;
    localparam int DRAIN    = 2200;
    localparam int N_RANDOM = 1000;
    localparam int N_DIR    = 26;

    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct {
        bpa_cmd_t cmd;
        bit       typed;
        bpa_res_t res;
    } directed_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  bytes;
    } grant_t;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_ready;
    bpa_cmd_t cmd;
    logic     res_valid;
    logic     res_ready;
    bpa_res_t res;

    bit       page_busy [NPAGES];
    bpa_res_t pending_results [$];
    grant_t   live_grants [$];
    bpa_res_t want;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       errors;
    int       n_sent;
    int       n_checked;
    int       n_granted;

    // opcode, address, end, length, align shift | typed expectation
    directed_row_t dir_rows [N_DIR] = '{
        '{'{OP_ALLOC_FIXED,   22'h000000, 23'h000000, 23'h001000, 5'd12}, 1'b1, '{22'h000000, ST_OK}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h001000, 5'd12}, 1'b1, '{22'h001000, ST_OK}},
        '{'{OP_FREE,          22'h000000, 23'h000000, 23'h002000, 5'd12}, 1'b1, '{22'h000000, ST_OK}},
        '{'{OP_MARK_FREE,     22'h000001, 23'h400000, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_UNALIGNED}},
        '{'{OP_RESERVE,       22'h3FFFFF, 23'h7FFFFF, 23'h000000, 5'd31}, 1'b1, '{22'h0, ST_UNALIGNED}},
        '{'{OP_ALLOC_FIXED,   22'h000800, 23'h000000, 23'h001000, 5'd12}, 1'b1, '{22'h0, ST_UNALIGNED}},
        '{'{OP_FREE,          22'h2AAAAA, 23'h000000, 23'h001000, 5'd12}, 1'b1, '{22'h0, ST_UNALIGNED}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h001000, 5'd11}, 1'b1, '{22'h0, ST_BADALIGN}},
        '{'{OP_ALLOC_ALIGNED, 22'h3FFFFF, 23'h7FFFFF, 23'h7FFFFF, 5'd0},  1'b1, '{22'h0, ST_BADALIGN}},
        '{'{OP_ALLOC_FIXED,   22'h3FF000, 23'h000000, 23'h002000, 5'd12}, 1'b1, '{22'h0, ST_RANGE}},
        '{'{OP_ALLOC_FIXED,   22'h000000, 23'h000000, 23'h7FFFFF, 5'd12}, 1'b1, '{22'h0, ST_RANGE}},
        '{'{OP_RESERVE,       22'h010000, 23'h010FFF, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_RESERVE,       22'h100000, 23'h200000, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_FIXED,   22'h1FF000, 23'h000000, 23'h000001, 5'd12}, 1'b1, '{22'h0, ST_BUSY}},
        '{'{OP_MARK_FREE,     22'h200000, 23'h7FFFFF, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_FREE,          22'h3FF000, 23'h000000, 23'h7FFFFF, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_FIXED,   22'h3FF000, 23'h000000, 23'h000000, 5'd12}, 1'b1, '{22'h3FF000, ST_OK}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h000000, 5'd13}, 1'b0, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h001000, 5'd21}, 1'b0, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h001000, 5'd22}, 1'b1, '{22'h0, ST_BUSY}},
        '{'{OP_UNDEF_HI,      22'h3FFFFF, 23'h7FFFFF, 23'h7FFFFF, 5'd31}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_RESERVE,       22'h000000, 23'h400000, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_ALIGNED, 22'h000000, 23'h000000, 23'h001000, 5'd12}, 1'b1, '{22'h0, ST_BUSY}},
        '{'{OP_MARK_FREE,     22'h000000, 23'h7FFFFF, 23'h000000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_ALLOC_FIXED,   22'h000000, 23'h000000, 23'h400000, 5'd12}, 1'b1, '{22'h0, ST_OK}},
        '{'{OP_FREE,          22'h000000, 23'h000000, 23'h400000, 5'd12}, 1'b1, '{22'h0, ST_OK}}
    };

    page_bitmap_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void fill_pages(longint lo, longint hi, bit v);
        for (longint p = lo; p < hi && p < NPAGES; p++)
            page_busy[p] = v;
    endfunction

    function automatic bit run_clear(longint first, longint n);
        if (first + n > NPAGES)
            return 1'b0;
        for (longint k = 0; k < n; k++)
            if (page_busy[first + k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Applies one request to the shadow bitmap and returns its outcome.
    function automatic bpa_res_t bitmap_outcome(bpa_cmd_t c);
        bpa_res_t r;
        longint   first;
        longint   n;
        longint   stop;
        longint   stride;
        longint   cand;
        bit       found;

        r = '0;
        r.status = ST_OK;
        first = longint'(c.address >> PSHIFT);
        n = longint'(c.length >> PSHIFT) + ((c.length[PSHIFT-1:0] != 0) ? 1 : 0);
        found = 1'b0;

        if ((c.opcode <= OP_ALLOC_FIXED || c.opcode == OP_FREE) && c.address[PSHIFT-1:0] != 0)
        begin
            r.status = ST_UNALIGNED;
            return r;
        end

        case (c.opcode)
            OP_MARK_FREE, OP_RESERVE:
            begin
                stop = longint'(c.end_address >> PSHIFT);
                if (stop > first)
                    fill_pages(first, stop, c.opcode == OP_RESERVE);
            end
            OP_ALLOC_FIXED:
            begin
                if (first + n > NPAGES)
                    r.status = ST_RANGE;
                else if (!run_clear(first, n))
                    r.status = ST_BUSY;
                else
                begin
                    fill_pages(first, first + n, 1'b1);
                    r.result_address = c.address;
                end
            end
            OP_ALLOC_ALIGNED:
            begin
                if (c.align_shift < PSHIFT)
                    r.status = ST_BADALIGN;
                else
                begin
                    stride = longint'(1) << (c.align_shift - PSHIFT);
                    cand = stride;
                    while (cand < NPAGES && !found)
                    begin
                        if (run_clear(cand, n))
                            found = 1'b1;
                        else
                            cand += stride;
                    end
                    if (found)
                    begin
                        fill_pages(cand, cand + n, 1'b1);
                        r.result_address = ADDR_W'(cand << PSHIFT);
                    end
                    else
                        r.status = ST_BUSY;
                end
            end
            OP_FREE:
            begin
                if (first < NPAGES)
                    fill_pages(first, first + n, 1'b0);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] few_pages_bytes();
        return LEN_W'($urandom_range(0, 8 * PAGE_B));
    endfunction

    function automatic logic [ADDR_W-1:0] page_base();
        return ADDR_W'($urandom_range(0, NPAGES - 1)) << PSHIFT;
    endfunction

    // Mostly well-formed allocate/free traffic; some region marking and raw noise.
    function automatic bpa_cmd_t random_request();
        bpa_cmd_t c;
        int       pick;
        int       idx;

        c.opcode      = OP_ALLOC_ALIGNED;
        c.address     = ADDR_W'($urandom);
        c.end_address = END_W'($urandom);
        c.length      = few_pages_bytes();
        c.align_shift = ASH_W'($urandom_range(12, 15));
        pick = $urandom_range(99);

        if (pick < 28)
        begin
            if ($urandom_range(9) == 0)
                c.align_shift = ASH_W'($urandom_range(16, 31));
            else if ($urandom_range(19) == 0)
                c.align_shift = ASH_W'($urandom_range(0, 11));
        end
        else if (pick < 48)
        begin
            c.opcode  = OP_ALLOC_FIXED;
            c.address = page_base();
            if ($urandom_range(9) == 0)
                c.length = LEN_W'($urandom);
        end
        else if (pick < 73)
        begin
            c.opcode = OP_FREE;
            if (live_grants.size() != 0)
            begin
                idx = $urandom_range(0, live_grants.size() - 1);
                c.address = live_grants[idx].base;
                c.length  = live_grants[idx].bytes;
                live_grants.delete(idx);
            end
            else
                c.address = page_base();
        end
        else if (pick < 85)
        begin
            c.opcode  = $urandom_range(1) ? OP_RESERVE : OP_MARK_FREE;
            c.address = page_base();
            if ($urandom_range(7) == 0)
                c.end_address = END_W'($urandom);
            else
                c.end_address = END_W'(c.address) + END_W'($urandom_range(0, 64 * PAGE_B));
        end
        else if (pick < 88)
        begin
            c.opcode      = OP_MARK_FREE;
            c.address     = '0;
            c.end_address = END_W'(NPAGES * PAGE_B);
        end
        else
        begin
            c.opcode      = OP_W'($urandom);
            c.align_shift = ASH_W'($urandom);
            if (c.opcode != OP_ALLOC_ALIGNED)
                c.length = LEN_W'($urandom);
        end
        return c;
    endfunction

    task automatic send_request(input bpa_cmd_t c);
        int gap;

        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        n_sent++;
    endtask

    task automatic note_outcome(input bpa_cmd_t c, input bpa_res_t r);
        if ((c.opcode == OP_ALLOC_FIXED || c.opcode == OP_ALLOC_ALIGNED) && r.status == ST_OK)
        begin
            n_granted++;
            live_grants.push_back('{r.result_address, c.length});
        end
        pending_results.push_back(r);
    endtask

    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: result_address %h status %0d",
                       res.result_address, res.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.result_address !== want.result_address)
                begin
                    $error("result_address: expected %h, got %h",
                           want.result_address, res.result_address);
                    errors++;
                end
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    initial
    begin
        bpa_cmd_t c;
        bpa_res_t r;

        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        send_idle_pct = 10;
        recv_idle_pct = 51;
        errors        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_granted     = 0;
        for (int p = 0; p < NPAGES; p++)
            page_busy[p] = 1'b0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            send_request(dir_rows[i].cmd);
            r = bitmap_outcome(dir_rows[i].cmd);
            note_outcome(dir_rows[i].cmd, dir_rows[i].typed ? dir_rows[i].res : r);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 51 : 0;
            recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 10 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++)
            begin
                c = random_request();
                send_request(c);
                note_outcome(c, bitmap_outcome(c));
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("run: %0d requests (%0d directed), %0d results checked", n_sent, N_DIR,
                 n_checked);
        $display("run: %0d allocations granted, %0d mismatches", n_granted, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
